// ----- sv/assert_macros.svh -----
// assertion macros for the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define FFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition never seen at a clock edge outside reset
`define FFA_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/ffa_pkg.sv -----
// shared types and constants of the first-fit allocator
`timescale 1ns / 1ps
package ffa_pkg;

    localparam int GRAN_BYTES = 8;
    localparam int GRAN_BITS  = 3;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [10:0] MIN_BLOCK_RESET = 11'd16;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_BADPTR = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] request_bytes;
        logic [15:0] payload_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_offset;
        logic [15:0] bytes_in_use;
        logic [15:0] peak_bytes_in_use;
        logic [31:0] bytes_ever_granted;
        logic [31:0] grant_count;
        logic [31:0] release_count;
    } t_result;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_ALLOC_START,
        OP_FREE_START,
        OP_SET_FAIL,
        OP_SET_BAD,
        OP_RD_CUR,
        OP_ACHK,
        OP_A_TAKE,
        OP_A_NEW,
        OP_FCHK,
        OP_RD_NXT,
        OP_FNCHK,
        OP_RD_PREV,
        OP_FPCHK,
        OP_F_WCUR,
        OP_F_INVCUR,
        OP_RD_FIX,
        OP_WR_FIX,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic [1:0] cmd;
        logic       req_zero;
        logic       off_bad;
        logic       fit;
        logic       split;
        logic       step_in;
        logic       hit;
        logic       rd_free;
        logic       cur_zero;
        logic       fix_in;
        logic       clr_last;
    } t_dp_sts;

endpackage

// ----- sv/ffa_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/ffa_datapath.sv -----
// allocator datapath: block header ram, walk registers and statistics
`timescale 1ns / 1ps
module ffa_datapath #(
    parameter int POOL_BYTES   = 65536,
    parameter int HEADER_BYTES = 40,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffa_pkg::t_in_item i_item,
    input  logic             i_cfg_we,
    input  logic [10:0]      i_cfg_wdata,
    input  ffa_pkg::t_dp_op  i_op,
    output ffa_pkg::t_dp_sts o_sts,
    output ffa_pkg::t_result o_result
);
    import ffa_pkg::*;

    localparam int DEPTH = POOL_BYTES / GRAN_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(POOL_BYTES) + 1;
    localparam int MW    = (SW + 2 > 19) ? SW + 2 : 19;
    localparam logic [MW-1:0] POOL_M = MW'(POOL_BYTES);
    localparam logic [MW-1:0] HDR_M  = MW'(HEADER_BYTES);
    localparam logic [MW-1:0] ALN_M  = MW'(ALIGN_BYTES - 1);

    typedef struct packed {
        logic                 valid;
        logic                 free;
        logic [GRAN_BITS-1:0] low;
        logic [SW-1:0]        size;
        logic [SW-1:0]        prev;
    } t_entry;

    localparam int EW = $bits(t_entry);

    function automatic logic [AW-1:0] gran(input logic [MW-1:0] a);
        return a[AW+GRAN_BITS-1:GRAN_BITS];
    endfunction

    logic [10:0]   r_min;
    logic [1:0]    r_cmd;
    logic [15:0]   r_req;
    logic [15:0]   r_off;
    logic [MW-1:0] r_need;
    logic [SW-1:0] r_cur;
    t_entry        r_ent;
    logic          r_split;
    logic [MW-1:0] r_nxt;
    logic [MW-1:0] r_fix;
    logic [SW-1:0] r_link;
    logic [SW-1:0] r_size;
    logic [AW-1:0] r_clr;
    logic [15:0]   r_used;
    logic [15:0]   r_peak;
    logic [31:0]   r_total;
    logic [31:0]   r_grants;
    logic [31:0]   r_releases;
    logic [1:0]    r_res_status;
    logic [15:0]   r_res_granted;
    t_result       r_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    t_entry        rd;

    logic [MW-1:0] cur_m;
    logic [MW-1:0] step;
    logic [MW-1:0] rnd;
    logic [MW-1:0] need_c;
    logic [MW-1:0] off_m;
    logic [MW-1:0] ns;
    logic [MW:0]   used_sum;
    logic [15:0]   used_grant;
    logic [15:0]   used_rel;
    logic          fit;
    logic          split_c;
    logic          hit;
    logic          step_in;
    t_entry        init_ent;

    ffa_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd      = t_entry'(ram_rdata);
    assign cur_m   = MW'(r_cur);
    assign step    = cur_m + HDR_M + MW'(rd.size);
    assign step_in = step < POOL_M;
    assign fit     = rd.free && (MW'(rd.size) >= r_need);
    assign split_c = MW'(rd.size) >= r_need + MW'(r_min) + HDR_M;
    assign hit     = rd.valid && (rd.low == r_cur[GRAN_BITS-1:0]);
    assign rnd     = (MW'(r_req) + ALN_M) & ~ALN_M;
    assign need_c  = (rnd < MW'(r_min)) ? MW'(r_min) : rnd;
    assign off_m   = MW'(r_off);
    assign ns      = cur_m + HDR_M + r_need;

    assign used_sum   = (MW+1)'(r_used) + (MW+1)'(r_need);
    assign used_grant = (used_sum > (MW+1)'(CNT_MAX)) ? CNT_MAX : used_sum[15:0];
    assign used_rel   = (MW'(r_used) >= MW'(rd.size)) ? (r_used - rd.size[15:0]) : 16'd0;

    always_comb begin
        init_ent       = '0;
        init_ent.valid = 1'b1;
        init_ent.free  = 1'b1;
        init_ent.size  = SW'(POOL_BYTES - HEADER_BYTES);
    end

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = gran(cur_m);
        ram_wdata = '0;
        ram_raddr = gran(cur_m);
        case (i_op)
            OP_CLR_STEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = (r_clr == '0) ? init_ent : '0;
            end
            OP_RD_CUR: begin
                ram_raddr = gran(cur_m);
            end
            OP_A_TAKE: begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b0;
                ram_wdata.low   = r_cur[GRAN_BITS-1:0];
                ram_wdata.size  = r_split ? SW'(r_need) : r_ent.size;
                ram_wdata.prev  = r_ent.prev;
            end
            OP_A_NEW: begin
                ram_we          = 1'b1;
                ram_waddr       = gran(ns);
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.low   = ns[GRAN_BITS-1:0];
                ram_wdata.size  = SW'(MW'(r_ent.size) - r_need - HDR_M);
                ram_wdata.prev  = r_cur;
            end
            OP_RD_NXT: begin
                ram_raddr = gran(r_nxt);
            end
            OP_FNCHK: begin
                ram_we    = rd.free;
                ram_waddr = gran(r_nxt);
            end
            OP_RD_PREV: begin
                ram_raddr = gran(MW'(r_ent.prev));
            end
            OP_FPCHK: begin
                ram_we          = rd.free;
                ram_waddr       = gran(MW'(r_ent.prev));
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.low   = r_ent.prev[GRAN_BITS-1:0];
                ram_wdata.size  = SW'(MW'(rd.size) + HDR_M + MW'(r_size));
                ram_wdata.prev  = rd.prev;
            end
            OP_F_WCUR: begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.low   = r_cur[GRAN_BITS-1:0];
                ram_wdata.size  = r_size;
                ram_wdata.prev  = r_ent.prev;
            end
            OP_F_INVCUR: begin
                ram_we = 1'b1;
            end
            OP_RD_FIX: begin
                ram_raddr = gran(r_fix);
            end
            OP_WR_FIX: begin
                ram_we         = 1'b1;
                ram_waddr      = gran(r_fix);
                ram_wdata      = rd;
                ram_wdata.prev = r_link;
            end
            default: begin
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= MIN_BLOCK_RESET;
            r_clr      <= '0;
            r_used     <= '0;
            r_peak     <= '0;
            r_total    <= '0;
            r_grants   <= '0;
            r_releases <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            case (i_op)
                OP_CLR_START: begin
                    r_clr      <= '0;
                    r_used     <= '0;
                    r_peak     <= '0;
                    r_total    <= '0;
                    r_grants   <= '0;
                    r_releases <= '0;
                end
                OP_CLR_STEP: begin
                    r_clr <= r_clr + AW'(1);
                end
                OP_A_TAKE: begin
                    r_used   <= used_grant;
                    r_peak   <= (used_grant > r_peak) ? used_grant : r_peak;
                    r_total  <= r_total + 32'(r_need);
                    r_grants <= r_grants + 32'd1;
                end
                OP_FCHK: begin
                    if (hit) begin
                        r_used     <= used_rel;
                        r_releases <= r_releases + 32'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // walk and result payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                r_cmd         <= i_item.command;
                r_req         <= i_item.request_bytes;
                r_off         <= i_item.payload_offset;
                r_res_status  <= ST_OK;
                r_res_granted <= '0;
            end
            OP_ALLOC_START: begin
                r_need <= need_c;
                r_cur  <= '0;
            end
            OP_FREE_START: begin
                r_cur <= SW'(off_m - HDR_M);
            end
            OP_SET_FAIL: begin
                r_res_status <= ST_FAIL;
            end
            OP_SET_BAD: begin
                r_res_status <= ST_BADPTR;
            end
            OP_ACHK: begin
                if (fit) begin
                    r_ent   <= rd;
                    r_split <= split_c;
                    r_nxt   <= step;
                end else begin
                    r_cur <= SW'(step);
                    if (!step_in) begin
                        r_res_status <= ST_FAIL;
                    end
                end
            end
            OP_A_TAKE: begin
                r_res_granted <= 16'(cur_m + HDR_M);
            end
            OP_A_NEW: begin
                r_fix  <= r_nxt;
                r_link <= SW'(ns);
            end
            OP_FCHK: begin
                if (hit) begin
                    r_ent  <= rd;
                    r_size <= rd.size;
                    r_nxt  <= step;
                end else begin
                    r_res_status <= ST_BADPTR;
                end
            end
            OP_FNCHK: begin
                if (rd.free) begin
                    r_size <= SW'(MW'(r_size) + HDR_M + MW'(rd.size));
                    r_fix  <= r_nxt + HDR_M + MW'(rd.size);
                    r_link <= r_cur;
                end
            end
            OP_FPCHK: begin
                if (rd.free) begin
                    r_fix  <= cur_m + HDR_M + MW'(r_size);
                    r_link <= r_ent.prev;
                end
            end
            OP_OUT: begin
                r_out.status             <= r_res_status;
                r_out.granted_offset     <= r_res_granted;
                r_out.bytes_in_use       <= r_used;
                r_out.peak_bytes_in_use  <= r_peak;
                r_out.bytes_ever_granted <= r_total;
                r_out.grant_count        <= r_grants;
                r_out.release_count      <= r_releases;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts          = '0;
        o_sts.cmd      = r_cmd;
        o_sts.req_zero = (r_req == 16'd0);
        o_sts.off_bad  = (off_m < HDR_M) || ((off_m - HDR_M) >= POOL_M);
        o_sts.fit      = fit;
        o_sts.split    = r_split;
        o_sts.step_in  = step_in;
        o_sts.hit      = hit;
        o_sts.rd_free  = rd.free;
        o_sts.cur_zero = (r_cur == '0);
        o_sts.fix_in   = r_fix < POOL_M;
        o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    end

    assign o_result = r_out;
endmodule

// ----- sv/ffa_ctrl.sv -----
// allocator controller state machine
`timescale 1ns / 1ps
module ffa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  ffa_pkg::t_dp_sts i_sts,
    output ffa_pkg::t_dp_op  o_op
);
    import ffa_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1 << 0,
        S_DISP   = 19'd1 << 1,
        S_CLEAR  = 19'd1 << 2,
        S_A_RD   = 19'd1 << 3,
        S_A_CHK  = 19'd1 << 4,
        S_A_TAKE = 19'd1 << 5,
        S_A_NEW  = 19'd1 << 6,
        S_F_RD   = 19'd1 << 7,
        S_F_CHK  = 19'd1 << 8,
        S_F_RDN  = 19'd1 << 9,
        S_F_NCHK = 19'd1 << 10,
        S_F_PRE  = 19'd1 << 11,
        S_F_PCHK = 19'd1 << 12,
        S_F_WCUR = 19'd1 << 13,
        S_F_INV  = 19'd1 << 14,
        S_FIXCHK = 19'd1 << 15,
        S_FX_RD  = 19'd1 << 16,
        S_FX_WR  = 19'd1 << 17,
        S_DONE   = 19'd1 << 18
    } t_state;

    t_state r_state, n_state;
    logic   r_ret_pre, n_ret_pre;
    logic   r_clr_out, n_clr_out;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state   = r_state;
        n_ret_pre = r_ret_pre;
        n_clr_out = r_clr_out;
        o_op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    CMD_ALLOC: begin
                        if (i_sts.req_zero) begin
                            o_op    = OP_SET_FAIL;
                            n_state = S_DONE;
                        end else begin
                            o_op    = OP_ALLOC_START;
                            n_state = S_A_RD;
                        end
                    end
                    CMD_FREE: begin
                        if (i_sts.off_bad) begin
                            o_op    = OP_SET_BAD;
                            n_state = S_DONE;
                        end else begin
                            o_op    = OP_FREE_START;
                            n_state = S_F_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        o_op      = OP_CLR_START;
                        n_clr_out = 1'b1;
                        n_state   = S_CLEAR;
                    end
                    default: begin
                        o_op    = OP_SET_FAIL;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CLEAR: begin
                o_op = OP_CLR_STEP;
                if (i_sts.clr_last) begin
                    n_clr_out = 1'b0;
                    n_state   = r_clr_out ? S_DONE : S_IDLE;
                end
            end
            S_A_RD: begin
                o_op    = OP_RD_CUR;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                o_op = OP_ACHK;
                if (i_sts.fit) begin
                    n_state = S_A_TAKE;
                end else if (!i_sts.step_in) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_TAKE: begin
                o_op    = OP_A_TAKE;
                n_state = i_sts.split ? S_A_NEW : S_DONE;
            end
            S_A_NEW: begin
                o_op      = OP_A_NEW;
                n_ret_pre = 1'b0;
                n_state   = S_FIXCHK;
            end
            S_F_RD: begin
                o_op    = OP_RD_CUR;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                o_op = OP_FCHK;
                if (!i_sts.hit) begin
                    n_state = S_DONE;
                end else if (i_sts.step_in) begin
                    n_state = S_F_RDN;
                end else begin
                    n_state = S_F_PRE;
                end
            end
            S_F_RDN: begin
                o_op    = OP_RD_NXT;
                n_state = S_F_NCHK;
            end
            S_F_NCHK: begin
                o_op = OP_FNCHK;
                if (i_sts.rd_free) begin
                    n_ret_pre = 1'b1;
                    n_state   = S_FIXCHK;
                end else begin
                    n_state = S_F_PRE;
                end
            end
            S_F_PRE: begin
                if (i_sts.cur_zero) begin
                    n_state = S_F_WCUR;
                end else begin
                    o_op    = OP_RD_PREV;
                    n_state = S_F_PCHK;
                end
            end
            S_F_PCHK: begin
                o_op    = OP_FPCHK;
                n_state = i_sts.rd_free ? S_F_INV : S_F_WCUR;
            end
            S_F_WCUR: begin
                o_op    = OP_F_WCUR;
                n_state = S_DONE;
            end
            S_F_INV: begin
                o_op      = OP_F_INVCUR;
                n_ret_pre = 1'b0;
                n_state   = S_FIXCHK;
            end
            S_FIXCHK: begin
                if (i_sts.fix_in) begin
                    n_state = S_FX_RD;
                end else begin
                    n_state = r_ret_pre ? S_F_PRE : S_DONE;
                end
            end
            S_FX_RD: begin
                o_op    = OP_RD_FIX;
                n_state = S_FX_WR;
            end
            S_FX_WR: begin
                o_op    = OP_WR_FIX;
                n_state = r_ret_pre ? S_F_PRE : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_op == OP_OUT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret_pre   <= 1'b0;
            r_clr_out   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret_pre   <= n_ret_pre;
            r_clr_out   <= n_clr_out;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `FFA_ASSERT(a_accept_dispatch, (i_in_valid && !o_in_stall) |=> (r_state == S_DISP), "accepted transfer not dispatched")
    `FFA_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result raised outside done")
    `FFA_ASSERT(a_fix_pair, (r_state == S_FX_RD) |=> (r_state == S_FX_WR), "link read without write back")
    `FFA_NEVER(a_no_overwrite, (o_op == OP_OUT) && r_out_valid && i_out_stall, "waiting result overwritten")
endmodule

// ----- sv/first_fit_block_allocator_top.sv -----
// top level of the first-fit block allocator
`timescale 1ns / 1ps
// alloc: one ram read per header walked to the first fit; a split adds a header and a link fix
// free: header reads, merges with free neighbours and link fix writes in the header ram
// clear: one header granule written per cycle over all POOL_BYTES/8 granules
// after reset a clearing pass over all POOL_BYTES/8 granules runs before the first transfer is taken
// the result sits in an output register, so the next item is taken while it waits
module first_fit_block_allocator_top #(
    parameter int POOL_BYTES   = 65536,
    parameter int HEADER_BYTES = 40,
    parameter int ALIGN_BYTES  = 8    // power of two
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: min_block_bytes
    input  logic              i_cfg_we,
    input  logic [10:0]       i_cfg_wdata,
    // command channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ffa_pkg::t_in_item i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ffa_pkg::t_result  o_out_data
);
    import ffa_pkg::*;

    // controller to datapath command, datapath to controller status
    t_dp_op  dp_op;
    t_dp_sts dp_sts;

    // sequencer: one-hot state machine walking the header list
    ffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_op        (dp_op)
    );

    // header ram, address arithmetic, statistics and output register
    ffa_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (dp_op),
        .o_sts       (dp_sts),
        .o_result    (o_out_data)
    );
endmodule
